/* rtl/rmd_pkg.sv */
// ----------------------------------------------------------------------------
// rmd_pkg
// Shared widths, basis masks and codeword rebuild for the RM(1,m) decoder.
// ----------------------------------------------------------------------------
package rmd_pkg;

  // fixed field widths of the beat payloads
  localparam int WORD_W      = 64;
  localparam int MSG_W       = 7;
  localparam int DIST_W      = 6;
  localparam int ORDER_M_DEF = 6;
  localparam int BASIS_N     = 6;

  // positions j whose bit k is set
  localparam logic [WORD_W-1:0] BASIS_MASK [BASIS_N] = '{
    64'hAAAA_AAAA_AAAA_AAAA,
    64'hCCCC_CCCC_CCCC_CCCC,
    64'hF0F0_F0F0_F0F0_F0F0,
    64'hFF00_FF00_FF00_FF00,
    64'hFFFF_0000_FFFF_0000,
    64'hFFFF_FFFF_0000_0000
  };

  // codeword of a message: xor of selected basis rows, complemented by the
  // constant term, cut to the code length
  function automatic logic [WORD_W-1:0] build_codeword(logic [MSG_W-1:0] msg, int order);
    logic [WORD_W-1:0] cw;
    logic [WORD_W-1:0] lmask;
    cw = '0;
    for (int k = 0; k < BASIS_N; k++) begin
      if ((k < order) && msg[k]) begin
        cw = cw ^ BASIS_MASK[k];
      end
    end
    if (msg[order]) begin
      cw = ~cw;
    end
    if (order >= BASIS_N) begin
      lmask = '1;
    end else begin
      lmask = (WORD_W'(1) << (1 << order)) - WORD_W'(1);
    end
    return cw & lmask;
  endfunction

endpackage

/* rtl/rmd_fht.sv */
// ----------------------------------------------------------------------------
// rmd_fht
// Pipelined fast Hadamard transform: one butterfly rank per register stage,
// gives the correlation of the received word with every linear codeword.
// ----------------------------------------------------------------------------
module rmd_fht #(
  parameter int ORDER_M = rmd_pkg::ORDER_M_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [rmd_pkg::WORD_W-1:0]  word_i,
  output logic                        valid_o,
  output logic signed [ORDER_M+1:0]   corr_o [1 << ORDER_M]
);
  import rmd_pkg::*;

  localparam int N     = 1 << ORDER_M;
  localparam int VAL_W = ORDER_M + 2;

  logic signed [VAL_W-1:0] x_in   [N];
  logic signed [VAL_W-1:0] src    [ORDER_M][N];
  logic signed [VAL_W-1:0] stg_q  [ORDER_M][N];
  logic [ORDER_M-1:0]      vld_q;

  // received bit 0 maps to +1, bit 1 to -1
  always_comb begin
    for (int j = 0; j < N; j++) begin
      x_in[j] = word_i[j] ? {VAL_W{1'b1}} : VAL_W'(1);
    end
  end

  // input of each butterfly rank
  always_comb begin
    for (int s = 0; s < ORDER_M; s++) begin
      for (int i = 0; i < N; i++) begin
        src[s][i] = (s == 0) ? x_in[i] : stg_q[(s == 0) ? 0 : s - 1][i];
      end
    end
  end

  // butterfly ranks, one register stage each
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < ORDER_M; s++) begin
        for (int i = 0; i < N; i++) begin
          if (((i >> s) & 1) == 0) begin
            stg_q[s][i] <= src[s][i] + src[s][i ^ (1 << s)];
          end else begin
            stg_q[s][i] <= src[s][i ^ (1 << s)] - src[s][i];
          end
        end
      end
    end
  end

  // valid bits travel with the ranks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      for (int s = 0; s < ORDER_M; s++) begin
        vld_q[s] <= (s == 0) ? valid_i : vld_q[(s == 0) ? 0 : s - 1];
      end
    end
  end

  assign valid_o = vld_q[ORDER_M-1];
  assign corr_o  = stg_q[ORDER_M-1];

endmodule

/* rtl/rmd_min_tree.sv */
// ----------------------------------------------------------------------------
// rmd_min_tree
// Turns correlations into sort keys {distance, constant term, linear part}
// and finds the smallest one through a registered pairwise tree.
// ----------------------------------------------------------------------------
module rmd_min_tree #(
  parameter int ORDER_M = rmd_pkg::ORDER_M_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [ORDER_M+1:0]   corr_i [1 << ORDER_M],
  output logic                        valid_o,
  output logic [2*ORDER_M:0]          key_o
);
  import rmd_pkg::*;

  localparam int N     = 1 << ORDER_M;
  localparam int VAL_W = ORDER_M + 2;
  localparam int KEY_W = 2 * ORDER_M + 1;

  logic [KEY_W-1:0]         leaf   [N];
  logic [KEY_W-1:0]         lvl_q  [ORDER_M+1][N];
  logic [ORDER_M:0]         vld_q;
  logic signed [VAL_W-1:0]  mag    [N];
  logic [VAL_W-1:0]         gap    [N];

  // leaf keys: a negative correlation prefers the complemented codeword,
  // a zero one keeps the plain codeword (lower message)
  always_comb begin
    for (int i = 0; i < N; i++) begin
      mag[i]  = corr_i[i][VAL_W-1] ? -corr_i[i] : corr_i[i];
      gap[i]  = VAL_W'(N) - mag[i];
      leaf[i] = {gap[i][ORDER_M:1], corr_i[i][VAL_W-1], ORDER_M'(i)};
    end
  end

  // leaf register and min levels; keys never tie since the index differs
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < N; i++) begin
        lvl_q[0][i] <= leaf[i];
      end
      for (int l = 1; l <= ORDER_M; l++) begin
        for (int i = 0; i < (N >> l); i++) begin
          lvl_q[l][i] <= (lvl_q[l-1][2*i] < lvl_q[l-1][2*i+1]) ?
                         lvl_q[l-1][2*i] : lvl_q[l-1][2*i+1];
        end
      end
    end
  end

  // valid bits follow the levels
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[ORDER_M-1:0], valid_i};
    end
  end

  assign valid_o = vld_q[ORDER_M];
  assign key_o   = lvl_q[ORDER_M][0];

endmodule

/* rtl/reed_muller_1_6_ml_decoder_top.sv */
// ----------------------------------------------------------------------------
// reed_muller_1_6_ml_decoder_top
// Maximum likelihood decoder for the first-order Reed-Muller code RM(1,m).
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o carry one received word per beat;
// bit j of received_word_i is the j-th received bit. Output channel:
// out_valid_o / out_stall_i carry the nearest codeword, its message (bit m is
// the constant term) and the Hamming distance. Ties go to the lowest message.
// A beat moves when valid is high and stall is low.
// Throughput: one word per cycle while no stall freezes the pipeline. From the
// accepting edge to out_valid_o a word passes ORDER_M butterfly ranks of
// the Hadamard transform, ORDER_M + 1 levels of the min tree and one output
// register. Depth is set by the transform and the tree.
// Stall: the output register is backed by a one-entry skid register; when
// both hold a beat the whole pipeline freezes and in_stall_o is high, so no
// beat is lost or repeated. in_stall_o comes from a register.
// Reset (rst_ni low, asynchronous): all valid bits clear, the block is empty
// and ready on the first cycle after reset.
// ----------------------------------------------------------------------------
module reed_muller_1_6_ml_decoder_top #(
  parameter int ORDER_M = rmd_pkg::ORDER_M_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [rmd_pkg::WORD_W-1:0]  received_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rmd_pkg::WORD_W-1:0]  decoded_codeword_o,
  output logic [rmd_pkg::MSG_W-1:0]   decoded_message_o,
  output logic [rmd_pkg::DIST_W-1:0]  error_distance_o
);
  import rmd_pkg::*;

  localparam int N     = 1 << ORDER_M;
  localparam int KEY_W = 2 * ORDER_M + 1;

  logic                       en;
  logic                       fht_valid;
  logic signed [ORDER_M+1:0]  corr [N];
  logic                       tree_valid;
  logic [KEY_W-1:0]           tree_key;

  logic [MSG_W-1:0]           fin_msg;
  logic [DIST_W-1:0]          fin_dist;
  logic [WORD_W-1:0]          fin_cw;

  logic                       out_valid_q;
  logic [WORD_W-1:0]          out_cw_q;
  logic [MSG_W-1:0]           out_msg_q;
  logic [DIST_W-1:0]          out_dist_q;
  logic                       skid_valid_q;
  logic [WORD_W-1:0]          skid_cw_q;
  logic [MSG_W-1:0]           skid_msg_q;
  logic [DIST_W-1:0]          skid_dist_q;

  logic                       push;
  logic                       out_free;

  // pipeline moves whenever the skid register is empty
  assign en         = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  rmd_fht #(.ORDER_M(ORDER_M)) u_fht (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .word_i  (received_word_i),
    .valid_o (fht_valid),
    .corr_o  (corr)
  );

  rmd_min_tree #(.ORDER_M(ORDER_M)) u_tree (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fht_valid),
    .corr_i  (corr),
    .valid_o (tree_valid),
    .key_o   (tree_key)
  );

  // unpack the winning key and rebuild its codeword
  assign fin_msg  = MSG_W'(tree_key[ORDER_M:0]);
  assign fin_dist = DIST_W'(tree_key[KEY_W-1 -: ORDER_M]);
  assign fin_cw   = build_codeword(fin_msg, ORDER_M);

  assign push     = tree_valid && en;
  assign out_free = !out_valid_q || !out_stall_i;

  // output register and skid valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || push;
      skid_valid_q <= 1'b0;
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  // output and skid payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_cw_q   <= skid_cw_q;
        out_msg_q  <= skid_msg_q;
        out_dist_q <= skid_dist_q;
      end else if (push) begin
        out_cw_q   <= fin_cw;
        out_msg_q  <= fin_msg;
        out_dist_q <= fin_dist;
      end
    end else if (push) begin
      skid_cw_q   <= fin_cw;
      skid_msg_q  <= fin_msg;
      skid_dist_q <= fin_dist;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign decoded_codeword_o = out_cw_q;
  assign decoded_message_o  = out_msg_q;
  assign error_distance_o   = out_dist_q;

endmodule

/* rtl/rmd_checker.sv */
// ----------------------------------------------------------------------------
// rmd_checker
// Port-level checks for the RM(1,m) decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rmd_checker #(
  parameter int ORDER_M = rmd_pkg::ORDER_M_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_stall_o,
  input  logic [rmd_pkg::WORD_W-1:0]  received_word_i,
  input  logic                        out_valid_o,
  input  logic                        out_stall_i,
  input  logic [rmd_pkg::WORD_W-1:0]  decoded_codeword_o,
  input  logic [rmd_pkg::MSG_W-1:0]   decoded_message_o,
  input  logic [rmd_pkg::DIST_W-1:0]  error_distance_o
);
  import rmd_pkg::*;

  // accepted input word is fully known
  a_in_known : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !$isunknown(received_word_i))
    else $error("unknown bits in accepted input word");

  // stalled output beat stays valid
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  // stalled output payload does not change
  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(decoded_codeword_o) &&
      $stable(decoded_message_o) && $stable(error_distance_o))
    else $error("output payload changed while stalled");

  // codeword agrees with its message
  a_cw_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> decoded_codeword_o == build_codeword(decoded_message_o, ORDER_M))
    else $error("codeword does not match message");

  // nearest codeword is never beyond half the code length
  a_dist_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> error_distance_o <= DIST_W'(1 << (ORDER_M - 1)))
    else $error("distance beyond half the code length");

endmodule

bind reed_muller_1_6_ml_decoder_top rmd_checker #(.ORDER_M(ORDER_M)) u_rmd_checker (.*);
